### rtl/pointer_drag_scroll_and_accel_core_defines.svh
// Assertion macros shared by the pointer drag-scroll and acceleration core.
`ifndef POINTER_DRAG_SCROLL_AND_ACCEL_CORE_DEFINES_SVH
`define POINTER_DRAG_SCROLL_AND_ACCEL_CORE_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define PDSA_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("pdsa: same-cycle check failed");

// Check a condition in the cycle after its trigger.
`define PDSA_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("pdsa: next-cycle check failed");

`endif

### rtl/pdsa_pkg.sv
// Package: constants, types and control structs of the drag-scroll and acceleration core.
`default_nettype none
package pdsa_pkg;

    localparam int DELTA_WIDTH_DEF = 16;
    localparam int ACC_W           = 16;
    localparam int OUT_W           = 16;
    localparam int WHEEL_W         = 8;
    localparam int TIME_W          = 32;
    localparam int T_W             = 10;
    localparam int MAG7_W          = 7;
    localparam int NUM_W           = 20;
    localparam int DEN_W           = 12;
    localparam int Q_W             = 8;
    localparam int STEP_W          = 5;
    localparam int THR_W           = 8;
    localparam int APB_AW          = 5;
    localparam int APB_DW          = 32;
    localparam int CNT_W           = $clog2(ACC_W);

    localparam int IDLE_LIMIT_MS   = 1000;
    localparam int IDLE_SUBST_MS   = 16;
    localparam int REPORT_MAX      = 127;
    localparam int THRESHOLD_RESET = 6;
    localparam int MUL_STEPS       = 7;
    localparam int DIV_STEPS       = 8;
    localparam int DEN_SHIFT       = 7;

    localparam logic signed [WHEEL_W-1:0] SCROLL_POS = 8'sd1;
    localparam logic signed [WHEEL_W-1:0] SCROLL_NEG = -8'sd1;

    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t REG_DRAG_ENABLE      = 3'd0;
    localparam reg_idx_t REG_ACCEL_STEP       = 3'd1;
    localparam reg_idx_t REG_SCROLL_THRESHOLD = 3'd2;
    localparam reg_idx_t REG_REVERSE_X        = 3'd3;
    localparam reg_idx_t REG_REVERSE_Y        = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DLOAD,
        S_DRAG,
        S_DSTEP,
        S_TIME,
        S_ALOAD,
        S_MUL1,
        S_SUM,
        S_MUL2,
        S_DIVINIT,
        S_DIV,
        S_OUT
    } pdsa_state_t;

    typedef struct packed {
        logic load;
        logic shift;
        logic step;
    } drag_ctl_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic sum;
        logic dinit;
        logic div;
    } accel_ctl_t;

endpackage
`default_nettype wire

### rtl/pointer_drag_scroll_and_accel_core.sv
// Top level: config registers, report sequencer, lanes and output register.
//
//   port group  | direction | handshake        | word
//   s_*         | in        | s_valid/s_ready  | delta_x, delta_y, wheel_h, wheel_v, now_ms
//   m_*         | out       | m_valid/m_ready  | out_x, out_y, out_h, out_v
//   p*          | in/out    | APB, pready = 1  | five config registers at 4*index
//
// One word at a time; the next word is taken once the result is loaded. Normal mode runs the
// 7-step serial multiplies and the 8-step restoring divide; drag mode runs the 16-step
// bit-serial accumulator add.
// Reset is synchronous, active low.
// A stalled result holds in the output register; the next word may be accepted meanwhile.
`default_nettype none
`include "pointer_drag_scroll_and_accel_core_defines.svh"
module pointer_drag_scroll_and_accel_core #(
    parameter int DELTA_WIDTH = pdsa_pkg::DELTA_WIDTH_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic signed [DELTA_WIDTH-1:0]         s_delta_x,
    input  wire logic signed [DELTA_WIDTH-1:0]         s_delta_y,
    input  wire logic signed [pdsa_pkg::WHEEL_W-1:0]   s_wheel_h,
    input  wire logic signed [pdsa_pkg::WHEEL_W-1:0]   s_wheel_v,
    input  wire logic [pdsa_pkg::TIME_W-1:0]           s_now_ms,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic signed [pdsa_pkg::OUT_W-1:0]          m_out_x,
    output logic signed [pdsa_pkg::OUT_W-1:0]          m_out_y,
    output logic signed [pdsa_pkg::WHEEL_W-1:0]        m_out_h,
    output logic signed [pdsa_pkg::WHEEL_W-1:0]       m_out_v,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [pdsa_pkg::APB_AW-1:0]           paddr,
    input  wire logic [pdsa_pkg::APB_DW-1:0]           pwdata,
    output logic [pdsa_pkg::APB_DW-1:0]                prdata,
    output logic                                       pready
);

    localparam int CW = pdsa_pkg::CNT_W;
    localparam int WW = pdsa_pkg::WHEEL_W;
    localparam int OW = pdsa_pkg::OUT_W;
    localparam int TW = pdsa_pkg::TIME_W;

    pdsa_pkg::pdsa_state_t state_reg, state_next;
    logic [CW-1:0]         cnt_reg, cnt_next;

    logic                         drag_en_reg, drag_en_next;
    logic [pdsa_pkg::STEP_W-1:0]  step_reg, step_next;
    logic [pdsa_pkg::THR_W-1:0]   thr_reg, thr_next;
    logic                         rev_x_reg, rev_x_next;
    logic                         rev_y_reg, rev_y_next;
    logic                         wr_en;
    pdsa_pkg::reg_idx_t           wr_idx;

    logic signed [DELTA_WIDTH-1:0] in_dx_reg, in_dx_next;
    logic signed [DELTA_WIDTH-1:0] in_dy_reg, in_dy_next;
    logic signed [WW-1:0]          in_wh_reg, in_wh_next;
    logic signed [WW-1:0]          in_wv_reg, in_wv_next;
    logic [TW-1:0]                 in_now_reg, in_now_next;
    logic [TW-1:0]                 last_reg, last_next;
    logic [pdsa_pkg::T_W-1:0]      t_reg, t_next;
    logic [TW-1:0]                 elapsed;
    logic                          moved;

    logic                 m_valid_reg, m_valid_next;
    logic signed [OW-1:0] out_x_reg, out_x_next;
    logic signed [OW-1:0] out_y_reg, out_y_next;
    logic signed [WW-1:0] out_h_reg, out_h_next;
    logic signed [WW-1:0] out_v_reg, out_v_next;

    logic                 accept, out_load, out_free;
    pdsa_pkg::drag_ctl_t  drag_ctl;
    pdsa_pkg::accel_ctl_t accel_ctl;
    logic signed [WW-1:0] drag_h, drag_v;
    logic signed [OW-1:0] res_x, res_y;

    // Configuration port
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign wr_idx = paddr[pdsa_pkg::APB_AW-1:2];

    always_comb begin
        drag_en_next = drag_en_reg;
        step_next    = step_reg;
        thr_next     = thr_reg;
        rev_x_next   = rev_x_reg;
        rev_y_next   = rev_y_reg;
        if (wr_en) begin
            unique case (wr_idx)
                pdsa_pkg::REG_DRAG_ENABLE:      drag_en_next = pwdata[0];
                pdsa_pkg::REG_ACCEL_STEP:       step_next    = pwdata[pdsa_pkg::STEP_W-1:0];
                pdsa_pkg::REG_SCROLL_THRESHOLD: thr_next     = pwdata[pdsa_pkg::THR_W-1:0];
                pdsa_pkg::REG_REVERSE_X:        rev_x_next   = pwdata[0];
                pdsa_pkg::REG_REVERSE_Y:        rev_y_next   = pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (wr_idx)
            pdsa_pkg::REG_DRAG_ENABLE:      prdata = pdsa_pkg::APB_DW'(drag_en_reg);
            pdsa_pkg::REG_ACCEL_STEP:       prdata = pdsa_pkg::APB_DW'(step_reg);
            pdsa_pkg::REG_SCROLL_THRESHOLD: prdata = pdsa_pkg::APB_DW'(thr_reg);
            pdsa_pkg::REG_REVERSE_X:        prdata = pdsa_pkg::APB_DW'(rev_x_reg);
            pdsa_pkg::REG_REVERSE_Y:        prdata = pdsa_pkg::APB_DW'(rev_y_reg);
            default:                        prdata = '0;
        endcase
    end

    // Sequencer: next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pdsa_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = drag_en_reg ? pdsa_pkg::S_DLOAD : pdsa_pkg::S_TIME;
                end
            end
            pdsa_pkg::S_DLOAD: state_next = pdsa_pkg::S_DRAG;
            pdsa_pkg::S_DRAG: begin
                if (cnt_reg == CW'(pdsa_pkg::ACC_W - 1)) begin
                    state_next = pdsa_pkg::S_DSTEP;
                end
            end
            pdsa_pkg::S_DSTEP: state_next = pdsa_pkg::S_OUT;
            pdsa_pkg::S_TIME:  state_next = pdsa_pkg::S_ALOAD;
            pdsa_pkg::S_ALOAD: state_next = pdsa_pkg::S_MUL1;
            pdsa_pkg::S_MUL1: begin
                if (cnt_reg == CW'(pdsa_pkg::MUL_STEPS - 1)) begin
                    state_next = pdsa_pkg::S_SUM;
                end
            end
            pdsa_pkg::S_SUM: state_next = pdsa_pkg::S_MUL2;
            pdsa_pkg::S_MUL2: begin
                if (cnt_reg == CW'(pdsa_pkg::MUL_STEPS - 1)) begin
                    state_next = pdsa_pkg::S_DIVINIT;
                end
            end
            pdsa_pkg::S_DIVINIT: state_next = pdsa_pkg::S_DIV;
            pdsa_pkg::S_DIV: begin
                if (cnt_reg == CW'(pdsa_pkg::DIV_STEPS - 1)) begin
                    state_next = pdsa_pkg::S_OUT;
                end
            end
            pdsa_pkg::S_OUT: begin
                if (out_free) begin
                    state_next = pdsa_pkg::S_IDLE;
                end
            end
            default: state_next = pdsa_pkg::S_IDLE;
        endcase
    end

    assign cnt_next = (state_next != state_reg) ? '0 : cnt_reg + 1'b1;
    assign out_free = !m_valid_reg || m_ready;

    // Sequencer: outputs
    always_comb begin
        s_ready   = 1'b0;
        out_load  = 1'b0;
        drag_ctl  = '0;
        accel_ctl = '0;
        unique case (state_reg)
            pdsa_pkg::S_IDLE:    s_ready         = 1'b1;
            pdsa_pkg::S_DLOAD:   drag_ctl.load   = 1'b1;
            pdsa_pkg::S_DRAG:    drag_ctl.shift  = 1'b1;
            pdsa_pkg::S_DSTEP:   drag_ctl.step   = 1'b1;
            pdsa_pkg::S_ALOAD:   accel_ctl.load  = 1'b1;
            pdsa_pkg::S_MUL1:    accel_ctl.mul   = 1'b1;
            pdsa_pkg::S_SUM:     accel_ctl.sum   = 1'b1;
            pdsa_pkg::S_MUL2:    accel_ctl.mul   = 1'b1;
            pdsa_pkg::S_DIVINIT: accel_ctl.dinit = 1'b1;
            pdsa_pkg::S_DIV:     accel_ctl.div   = 1'b1;
            pdsa_pkg::S_OUT:     out_load        = out_free;
            default: begin
            end
        endcase
    end

    assign accept = s_valid & s_ready;

    // Input capture and elapsed time
    assign elapsed = in_now_reg - last_reg;
    assign moved   = (in_dx_reg != '0) || (in_dy_reg != '0);

    always_comb begin
        in_dx_next  = accept ? s_delta_x : in_dx_reg;
        in_dy_next  = accept ? s_delta_y : in_dy_reg;
        in_wh_next  = accept ? s_wheel_h : in_wh_reg;
        in_wv_next  = accept ? s_wheel_v : in_wv_reg;
        in_now_next = accept ? s_now_ms  : in_now_reg;
        t_next      = t_reg;
        last_next   = last_reg;
        if (state_reg == pdsa_pkg::S_TIME) begin
            t_next = (elapsed > TW'(pdsa_pkg::IDLE_LIMIT_MS))
                   ? pdsa_pkg::T_W'(pdsa_pkg::IDLE_SUBST_MS) : elapsed[pdsa_pkg::T_W-1:0];
            if (moved) begin
                last_next = in_now_reg;
            end
        end
    end

    // Output register
    always_comb begin
        out_x_next   = out_x_reg;
        out_y_next   = out_y_reg;
        out_h_next   = out_h_reg;
        out_v_next   = out_v_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        if (out_load) begin
            m_valid_next = 1'b1;
            out_x_next   = drag_en_reg ? '0 : res_x;
            out_y_next   = drag_en_reg ? '0 : res_y;
            out_h_next   = drag_en_reg ? drag_h : in_wh_reg;
            out_v_next   = drag_en_reg ? drag_v : in_wv_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pdsa_pkg::S_IDLE;
            cnt_reg     <= '0;
            drag_en_reg <= 1'b0;
            step_reg    <= '0;
            thr_reg     <= pdsa_pkg::THR_W'(pdsa_pkg::THRESHOLD_RESET);
            rev_x_reg   <= 1'b0;
            rev_y_reg   <= 1'b0;
            last_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            drag_en_reg <= drag_en_next;
            step_reg    <= step_next;
            thr_reg     <= thr_next;
            rev_x_reg   <= rev_x_next;
            rev_y_reg   <= rev_y_next;
            last_reg    <= last_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_dx_reg  <= in_dx_next;
        in_dy_reg  <= in_dy_next;
        in_wh_reg  <= in_wh_next;
        in_wv_reg  <= in_wv_next;
        in_now_reg <= in_now_next;
        t_reg      <= t_next;
        out_x_reg  <= out_x_next;
        out_y_reg  <= out_y_next;
        out_h_reg  <= out_h_next;
        out_v_reg  <= out_v_next;
    end

    assign m_valid = m_valid_reg;
    assign m_out_x = out_x_reg;
    assign m_out_y = out_y_reg;
    assign m_out_h = out_h_reg;
    assign m_out_v = out_v_reg;

    pdsa_drag_lane #(.DELTA_WIDTH(DELTA_WIDTH)) u_drag_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (drag_ctl),
        .delta     (in_dx_reg),
        .rev       (rev_x_reg),
        .thr       (thr_reg),
        .wheel     (in_wh_reg),
        .wheel_out (drag_h)
    );

    pdsa_drag_lane #(.DELTA_WIDTH(DELTA_WIDTH)) u_drag_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (drag_ctl),
        .delta     (in_dy_reg),
        .rev       (rev_y_reg),
        .thr       (thr_reg),
        .wheel     (in_wv_reg),
        .wheel_out (drag_v)
    );

    pdsa_accel_lane #(.DELTA_WIDTH(DELTA_WIDTH)) u_accel_x (
        .aclk  (aclk),
        .ctl   (accel_ctl),
        .delta (in_dx_reg),
        .t     (t_reg),
        .step  (step_reg),
        .res   (res_x)
    );

    pdsa_accel_lane #(.DELTA_WIDTH(DELTA_WIDTH)) u_accel_y (
        .aclk  (aclk),
        .ctl   (accel_ctl),
        .delta (in_dy_reg),
        .t     (t_reg),
        .step  (step_reg),
        .res   (res_y)
    );

    `PDSA_ASSERT_NEXT(a_accept_leaves_idle, s_valid && s_ready, state_reg != pdsa_pkg::S_IDLE)
    `PDSA_ASSERT_NEXT(a_load_sets_valid, out_load, m_valid)
    `PDSA_ASSERT_NEXT(a_stamp_only_in_time, state_reg != pdsa_pkg::S_TIME, $stable(last_reg))
    `PDSA_ASSERT_NOW(a_lanes_idle_when_ready, s_ready, (accel_ctl == '0) && (drag_ctl == '0))

endmodule
`default_nettype wire

### rtl/pdsa_drag_lane.sv
// Drag-scroll lane: bit-serial accumulator update and scroll step decision for one axis.
`default_nettype none
module pdsa_drag_lane #(
    parameter int DELTA_WIDTH = pdsa_pkg::DELTA_WIDTH_DEF
) (
    input  wire logic                                      aclk,
    input  wire logic                                      aresetn,
    input  wire pdsa_pkg::drag_ctl_t                       ctl,
    input  wire logic signed [DELTA_WIDTH-1:0]             delta,
    input  wire logic                                      rev,
    input  wire logic [pdsa_pkg::THR_W-1:0]                thr,
    input  wire logic signed [pdsa_pkg::WHEEL_W-1:0]       wheel,
    output logic signed [pdsa_pkg::WHEEL_W-1:0]            wheel_out
);

    localparam int AW = pdsa_pkg::ACC_W;

    logic [AW-1:0]                       acc_reg, acc_next;
    logic [AW-1:0]                       addend_reg, addend_next;
    logic                                carry_reg, carry_next;
    logic signed [pdsa_pkg::WHEEL_W-1:0] wheel_reg, wheel_next;
    logic                                sum_bit, carry_out;
    logic [AW:0]                         mag;
    logic                                over;

    assign sum_bit   = acc_reg[0] ^ addend_reg[0] ^ carry_reg;
    assign carry_out = (acc_reg[0] & addend_reg[0]) | (acc_reg[0] & carry_reg)
                     | (addend_reg[0] & carry_reg);
    assign mag  = acc_reg[AW-1] ? ((AW+1)'(1) << AW) - (AW+1)'(acc_reg) : (AW+1)'(acc_reg);
    assign over = mag > (AW+1)'(thr);

    always_comb begin
        acc_next    = acc_reg;
        addend_next = addend_reg;
        carry_next  = carry_reg;
        wheel_next  = wheel_reg;
        if (ctl.load) begin
            addend_next = AW'(delta) ^ {AW{rev}};
            carry_next  = rev;
        end
        if (ctl.shift) begin
            acc_next    = {sum_bit, acc_reg[AW-1:1]};
            addend_next = addend_reg >> 1;
            carry_next  = carry_out;
        end
        if (ctl.step) begin
            if (over) begin
                acc_next   = '0;
                wheel_next = acc_reg[AW-1] ? pdsa_pkg::SCROLL_NEG : pdsa_pkg::SCROLL_POS;
            end else begin
                wheel_next = wheel;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        addend_reg <= addend_next;
        carry_reg  <= carry_next;
        wheel_reg  <= wheel_next;
    end

    assign wheel_out = wheel_reg;

endmodule
`default_nettype wire

### rtl/pdsa_accel_lane.sv
// Acceleration lane: serial shift-add products and restoring divide for one axis.
`default_nettype none
module pdsa_accel_lane #(
    parameter int DELTA_WIDTH = pdsa_pkg::DELTA_WIDTH_DEF
) (
    input  wire logic                                 aclk,
    input  wire pdsa_pkg::accel_ctl_t                 ctl,
    input  wire logic signed [DELTA_WIDTH-1:0]        delta,
    input  wire logic [pdsa_pkg::T_W-1:0]             t,
    input  wire logic [pdsa_pkg::STEP_W-1:0]          step,
    output logic signed [pdsa_pkg::OUT_W-1:0]         res
);

    localparam int CW = (DELTA_WIDTH > pdsa_pkg::T_W) ? DELTA_WIDTH : pdsa_pkg::T_W;
    localparam int NW = pdsa_pkg::NUM_W;
    localparam int MW = pdsa_pkg::MAG7_W;
    localparam int QW = pdsa_pkg::Q_W;
    localparam int OW = pdsa_pkg::OUT_W;
    localparam int DW = pdsa_pkg::DEN_W;

    logic [DELTA_WIDTH-1:0] mag_w;
    logic                   pass, big, gt, comp;
    logic [MW-1:0]          fix7, t7, diff7, val7;
    logic [DW-1:0]          den;
    logic                   ge;
    logic signed [OW-1:0]   dext;

    logic          pass_reg, pass_next;
    logic          comp_reg, comp_next;
    logic          neg_reg, neg_next;
    logic [MW-1:0] fix_reg, fix_next;
    logic [NW-1:0] acc_reg, acc_next;
    logic [NW-1:0] mcand_reg, mcand_next;
    logic [MW-1:0] mplr_reg, mplr_next;
    logic [QW-1:0] q_reg, q_next;

    assign mag_w = delta[DELTA_WIDTH-1] ? (~delta + 1'b1) : delta;
    assign pass  = (t == '0) || (delta == '0);
    assign big   = mag_w >= DELTA_WIDTH'(pdsa_pkg::REPORT_MAX);
    assign gt    = CW'(mag_w) > CW'(t);
    assign comp  = !pass && gt && !big;
    assign fix7  = big ? MW'(pdsa_pkg::REPORT_MAX) : mag_w[MW-1:0];
    assign t7    = t[MW-1:0];
    assign diff7 = mag_w[MW-1:0] - t7;
    assign den   = (DW'(t7) << 4) + (DW'(t7) << 2);
    assign ge    = acc_reg >= mcand_reg;

    always_comb begin
        pass_next  = pass_reg;
        comp_next  = comp_reg;
        neg_next   = neg_reg;
        fix_next   = fix_reg;
        acc_next   = acc_reg;
        mcand_next = mcand_reg;
        mplr_next  = mplr_reg;
        q_next     = q_reg;
        if (ctl.load) begin
            pass_next  = pass;
            comp_next  = comp;
            neg_next   = delta[DELTA_WIDTH-1];
            fix_next   = fix7;
            acc_next   = '0;
            mcand_next = NW'(diff7);
            mplr_next  = MW'(step);
        end
        if (ctl.mul) begin
            if (mplr_reg[0]) begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next = {mcand_reg[NW-2:0], 1'b0};
            mplr_next  = mplr_reg >> 1;
        end
        if (ctl.sum) begin
            mcand_next = acc_reg + NW'(den);
            acc_next   = '0;
            mplr_next  = mag_w[MW-1:0];
        end
        if (ctl.dinit) begin
            mcand_next = NW'(den) << pdsa_pkg::DEN_SHIFT;
            q_next     = '0;
        end
        if (ctl.div) begin
            if (ge) begin
                acc_next = acc_reg - mcand_reg;
            end
            q_next     = {q_reg[QW-2:0], ge};
            mcand_next = mcand_reg >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        pass_reg  <= pass_next;
        comp_reg  <= comp_next;
        neg_reg   <= neg_next;
        fix_reg   <= fix_next;
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
        mplr_reg  <= mplr_next;
        q_reg     <= q_next;
    end

    assign dext = OW'(delta);
    assign val7 = comp_reg ? (q_reg[QW-1] ? MW'(pdsa_pkg::REPORT_MAX) : q_reg[MW-1:0])
                           : fix_reg;

    always_comb begin
        if (pass_reg) begin
            res = dext;
        end else if (neg_reg) begin
            res = OW'(0) - OW'(val7);
        end else begin
            res = OW'(val7);
        end
    end

endmodule
`default_nettype wire
